FILE: sv/sqmm_pkg.sv
// Shared widths, request codes and cell-chain structs for the square matrix multiplier.
// No dependencies; imported by the interfaces, the cell and the top level.
`default_nettype none

package sqmm_pkg;

   localparam int DATA_W = 32;   // element and product width
   localparam int IDX_W  = 3;    // row / column index width
   localparam int DIM_W  = 4;    // dimension register width
   localparam int KIND_W = 2;    // request code width

   localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

   localparam logic [KIND_W-1:0] REQ_WRITE_A = 2'd0;
   localparam logic [KIND_W-1:0] REQ_WRITE_B = 2'd1;
   localparam logic [KIND_W-1:0] REQ_COMPUTE = 2'd2;

   // One step of a dot product, handed from cell to cell.
   typedef struct packed {
      logic              vld;
      logic              first;   // t == 0: restart accumulator
      logic              last;    // t == n-1: accumulator complete
      logic [IDX_W-1:0]  t;       // inner index, selects the B row
      logic [DATA_W-1:0] a;       // A[i][t]
   } token_type;

   // B element write, broadcast to all cells; the cell owning col keeps it.
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [DATA_W-1:0] data;
   } bwr_type;

endpackage

`default_nettype wire

FILE: sv/sqmm_req_if.sv
// Request channel: valid/ready handshake with element write or compute payload.
// Depends on sqmm_pkg for field widths.
`default_nettype none

interface sqmm_req_if;
   import sqmm_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        req_type;
   logic [IDX_W-1:0]         row;
   logic [IDX_W-1:0]         col;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, req_type, row, col, value, input ready);
   modport sink   (input valid, req_type, row, col, value, output ready);
endinterface

`default_nettype wire

FILE: sv/sqmm_rsp_if.sv
// Response channel: valid/ready handshake carrying one product element per transfer.
// Depends on sqmm_pkg for field widths.
`default_nettype none

interface sqmm_rsp_if;
   import sqmm_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [IDX_W-1:0]         out_row;
   logic [IDX_W-1:0]         out_col;
   logic signed [DATA_W-1:0] product;
   logic                     last;

   modport source (output valid, out_row, out_col, product, last, input ready);
   modport sink   (input valid, out_row, out_col, product, last, output ready);
endinterface

`default_nettype wire

FILE: sv/square_int_matrix_multiply.sv
// Square signed 32-bit matrix multiplier built on a chain of MAC cells.
// Writes of A or B are taken only while idle. A compute runs row by row: A[i][0..n-1]
// is issued into the cell chain, each cell multiplies and accumulates its column of B,
// then the n elements of product row i are handed out before the next row is issued.
// Reset (synchronous, active high) clears control state and sets dimension to 8;
// the A and B stores are not cleared and hold garbage until written.
// Depends on sqmm_pkg, sqmm_req_if, sqmm_rsp_if and sqmm_cell.
`default_nettype none

module square_int_matrix_multiply #(
   parameter int MAX_DIM = 8
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   sqmm_req_if.sink                         req_ch,
   sqmm_rsp_if.source                       rsp_ch,
   input  wire logic                        csr_we,
   input  wire logic [sqmm_pkg::DIM_W-1:0]  csr_wdata
);
   import sqmm_pkg::*;

   // Index fields are 3 bits, so at most 8 rows/cols are reachable.
   localparam int LIM = (MAX_DIM < 8) ? MAX_DIM : 8;
   localparam int IW  = (LIM > 1) ? $clog2(LIM) : 1;
   localparam int AW  = (LIM > 1) ? $clog2(LIM * LIM) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,    // take writes and compute requests
      ST_ISSUE,   // stream A[i][0..n-1] into the chain
      ST_WAIT,    // wait for the far cell to finish row i
      ST_DRAIN    // hand out row i, one element per transfer
   } state_type;

   state_type          state_ff;
   logic [DIM_W-1:0]   dim_ff;
   logic [DIM_W-1:0]   n_ff, eff_n;
   logic [IDX_W-1:0]   i_ff, t_ff;
   logic [DIM_W-1:0]   j_ff;

   // token metadata for cell 0; A data comes from the store read register
   logic               tk_vld_ff, tk_first_ff, tk_last_ff;
   logic [IDX_W-1:0]   tk_t_ff;
   logic [DATA_W-1:0]  a_rd_ff;

   // response output register
   logic               rsp_vld_ff, rsp_last_ff;
   logic [IDX_W-1:0]   rsp_row_ff, rsp_col_ff;
   logic [DATA_W-1:0]  rsp_prod_ff;

   logic [DATA_W-1:0]  amem [LIM * LIM];
   logic [AW-1:0]      a_waddr, a_raddr;
   logic               req_xfer, a_we, in_range, rsp_free, t_end;

   token_type          tok [LIM + 1];
   logic [DATA_W-1:0]  acc [LIM];
   logic [LIM-1:0]     cell_done;
   bwr_type            bwr;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;

   // a write whose row or col lies beyond the usable block is dropped
   assign in_range = ({1'b0, req_ch.row} < (IDX_W + 1)'(LIM))
                     && ({1'b0, req_ch.col} < (IDX_W + 1)'(LIM));
   assign a_we     = req_xfer && (req_ch.req_type == REQ_WRITE_A) && in_range;
   assign a_waddr  = AW'(int'(req_ch.row) * LIM + int'(req_ch.col));
   assign a_raddr  = AW'(int'(i_ff) * LIM + int'(t_ff));

   assign bwr.en   = req_xfer && (req_ch.req_type == REQ_WRITE_B);
   assign bwr.row  = req_ch.row;
   assign bwr.col  = req_ch.col;
   assign bwr.data = req_ch.value;

   // dimension zero acts as 1, large values saturate to the cell count
   always_comb begin
      if (dim_ff == '0) begin
         eff_n = DIM_W'(1);
      end else if (dim_ff > DIM_W'(LIM)) begin
         eff_n = DIM_W'(LIM);
      end else begin
         eff_n = dim_ff;
      end
   end

   assign t_end    = ({1'b0, t_ff} == (n_ff - DIM_W'(1)));
   assign rsp_free = !rsp_vld_ff || rsp_ch.ready;

   // A store, row-major with stride LIM; registered read feeds cell 0
   always_ff @(posedge clock) begin
      if (a_we) begin
         amem[a_waddr] <= req_ch.value;
      end
      a_rd_ff <= amem[a_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         dim_ff     <= DIM_RESET;
         tk_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         // one token per issue cycle
         tk_vld_ff <= (state_ff == ST_ISSUE);
         if (csr_we) begin
            dim_ff <= csr_wdata;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_xfer && (req_ch.req_type == REQ_COMPUTE)) begin
                  n_ff     <= eff_n;
                  i_ff     <= '0;
                  t_ff     <= '0;
                  state_ff <= ST_ISSUE;
               end
            end
            ST_ISSUE: begin
               tk_first_ff <= (t_ff == '0);
               tk_last_ff  <= t_end;
               tk_t_ff     <= t_ff;
               t_ff        <= t_ff + IDX_W'(1);
               if (t_end) begin
                  state_ff <= ST_WAIT;
               end
            end
            ST_WAIT: begin
               // far cell is last to finish; all nearer ones are done by now
               j_ff <= '0;
               if (cell_done[LIM-1]) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (rsp_free) begin
                  if (j_ff < n_ff) begin
                     rsp_vld_ff  <= 1'b1;
                     rsp_prod_ff <= acc[j_ff[IW-1:0]];
                     rsp_row_ff  <= i_ff;
                     rsp_col_ff  <= j_ff[IDX_W-1:0];
                     rsp_last_ff <= ({1'b0, i_ff} == (n_ff - DIM_W'(1)))
                                    && (j_ff == (n_ff - DIM_W'(1)));
                     j_ff        <= j_ff + DIM_W'(1);
                  end else begin
                     // row fully transferred: next row or done
                     rsp_vld_ff <= 1'b0;
                     t_ff       <= '0;
                     if ({1'b0, i_ff} == (n_ff - DIM_W'(1))) begin
                        state_ff <= ST_IDLE;
                     end else begin
                        i_ff     <= i_ff + IDX_W'(1);
                        state_ff <= ST_ISSUE;
                     end
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // cell chain: token enters cell 0, each cell registers it and hands it on
   always_comb begin
      tok[0].vld   = tk_vld_ff;
      tok[0].first = tk_first_ff;
      tok[0].last  = tk_last_ff;
      tok[0].t     = tk_t_ff;
      tok[0].a     = a_rd_ff;
   end

   for (genvar g = 0; g < LIM; g++) begin : g_cell
      sqmm_cell #(
         .LIM      (LIM),
         .CELL_IDX (g)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .tok_i  (tok[g]),
         .tok_o  (tok[g+1]),
         .bwr    (bwr),
         .acc_o  (acc[g]),
         .done_o (cell_done[g])
      );
   end

   assign rsp_ch.valid   = rsp_vld_ff;
   assign rsp_ch.out_row = rsp_row_ff;
   assign rsp_ch.out_col = rsp_col_ff;
   assign rsp_ch.product = rsp_prod_ff;
   assign rsp_ch.last    = rsp_last_ff;

`ifndef SYNTHESIS
   // results only leave while a row is being drained
   a_rsp_in_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (state_ff == ST_DRAIN))
      else $error("response valid outside drain");

   // the far cell completes a row only while the sequencer waits for it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      cell_done[LIM-1] |-> (state_ff == ST_WAIT))
      else $error("cell chain finished outside wait");

   // the final element is on the diagonal
   a_last_diag: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_last_ff) |-> (rsp_row_ff == rsp_col_ff))
      else $error("last flag off the diagonal");

   // drain column counter never passes the dimension
   a_j_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (j_ff <= n_ff))
      else $error("drain column out of range");
`endif

endmodule

`default_nettype wire

FILE: sv/sqmm_cell.sv
// One multiply-accumulate cell of the chain: owns column CELL_IDX of B and the
// accumulator for that output column. Depends on sqmm_pkg.
`default_nettype none

module sqmm_cell #(
   parameter int LIM      = 8,
   parameter int CELL_IDX = 0
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sqmm_pkg::token_type           tok_i,
   output      sqmm_pkg::token_type           tok_o,
   input  wire sqmm_pkg::bwr_type             bwr,
   output      logic [sqmm_pkg::DATA_W-1:0]   acc_o,
   output      logic                          done_o
);
   import sqmm_pkg::*;

   localparam int IW = (LIM > 1) ? $clog2(LIM) : 1;

   typedef struct packed {
      logic vld;
      logic first;
      logic last;
   } ctl_type;

   logic [DATA_W-1:0] bmem [LIM];

   token_type         s0_ff;
   ctl_type           s1_ff, s2_ff;
   logic [DATA_W-1:0] a1_ff, b_rd_ff, prod_ff, acc_ff;
   logic              done_ff;
   logic              b_we;

   assign b_we = bwr.en && (bwr.col == IDX_W'(CELL_IDX))
                 && ({1'b0, bwr.row} < (IDX_W + 1)'(LIM));

   // column store, registered read at the inner index
   always_ff @(posedge clock) begin
      if (b_we) begin
         bmem[bwr.row[IW-1:0]] <= bwr.data;
      end
      b_rd_ff <= bmem[s0_ff.t[IW-1:0]];
      a1_ff   <= s0_ff.a;
      prod_ff <= a1_ff * b_rd_ff;   // low 32 bits, same for signed
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.vld <= 1'b0;
         s1_ff     <= '0;
         s2_ff     <= '0;
         done_ff   <= 1'b0;
      end else begin
         s0_ff   <= tok_i;
         s1_ff   <= '{vld: s0_ff.vld, first: s0_ff.first, last: s0_ff.last};
         s2_ff   <= s1_ff;
         done_ff <= s2_ff.vld && s2_ff.last;
         if (s2_ff.vld) begin
            acc_ff <= s2_ff.first ? prod_ff : acc_ff + prod_ff;
         end
      end
   end

   assign tok_o  = s0_ff;
   assign acc_o  = acc_ff;
   assign done_o = done_ff;

endmodule

`default_nettype wire

FILE: verif/sqmm_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the square matrix multiplier: watches request, response and register ports,
// keeps its own copy of A, B and the dimension, and checks every product element in order.
// Depends on sqmm_pkg, sqmm_req_if and sqmm_rsp_if.
module sqmm_checker #(
   parameter int MAX_DIM = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   sqmm_req_if                        req_mon,
   sqmm_rsp_if                        rsp_mon,
   input  logic                       csr_we,
   input  logic [sqmm_pkg::DIM_W-1:0] csr_wdata,
   output int                         fail_count,
   output int                         pending_count
);
   import sqmm_pkg::*;

   localparam int DIM_CAP = (MAX_DIM < 8) ? MAX_DIM : 8;

   typedef struct {
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [DATA_W-1:0] value;
      logic              last;
   } elem_type;

   logic [DATA_W-1:0] a_mat [MAX_DIM*MAX_DIM];
   logic [DATA_W-1:0] b_mat [MAX_DIM*MAX_DIM];
   logic [DIM_W-1:0]  dim_reg = DIM_RESET;
   elem_type          product_queue [$];
   int                mismatches = 0;

   // One line per mismatch, and count it.
   task automatic report_mismatch(input string what);
      $display("%0t ns  mismatch: %s", $time, what);
      mismatches++;
   endtask

   // Full A*B at the current size, row-major, wrapped to 32 bits.
   task automatic predict_product();
      int                n;
      logic [DATA_W-1:0] acc;
      elem_type          e;
      n = (dim_reg == 0) ? 1 : (dim_reg > DIM_CAP) ? DIM_CAP : int'(dim_reg);
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            acc = '0;
            for (int t = 0; t < n; t++)
               acc = acc + a_mat[i*MAX_DIM + t] * b_mat[t*MAX_DIM + j];
            e.row   = IDX_W'(i);
            e.col   = IDX_W'(j);
            e.value = acc;
            e.last  = (i == n - 1) && (j == n - 1);
            product_queue.insert(product_queue.size(), e);
         end
      end
   endtask

   always @(posedge clock) begin : monitor
      elem_type e;
      if (reset) begin
         dim_reg = DIM_RESET;
         product_queue.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (product_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected element (%0d,%0d) = %0d",
                  rsp_mon.out_row, rsp_mon.out_col, rsp_mon.product));
            end else begin
               e = product_queue.pop_front();
               if (rsp_mon.out_row !== e.row)
                  report_mismatch($sformatf("out_row %0d, want %0d", rsp_mon.out_row, e.row));
               if (rsp_mon.out_col !== e.col)
                  report_mismatch($sformatf("out_col %0d, want %0d", rsp_mon.out_col, e.col));
               if (rsp_mon.product !== e.value)
                  report_mismatch($sformatf("product (%0d,%0d) %h, want %h",
                     e.row, e.col, rsp_mon.product, e.value));
               if (rsp_mon.last !== e.last)
                  report_mismatch($sformatf("last (%0d,%0d) %b, want %b",
                     e.row, e.col, rsp_mon.last, e.last));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.req_type)
               REQ_WRITE_A: a_mat[req_mon.row*MAX_DIM + req_mon.col] = req_mon.value;
               REQ_WRITE_B: b_mat[req_mon.row*MAX_DIM + req_mon.col] = req_mon.value;
               REQ_COMPUTE: predict_product();
               default: ;
            endcase
         end
         if (csr_we)
            dim_reg = csr_wdata;
      end
      fail_count    <= mismatches;
      pending_count <= product_queue.size();
   end

endmodule

FILE: verif/square_int_matrix_multiply_tb.sv
`timescale 1ns / 1ps
// Top of the square matrix multiplier testbench: clock, reset, dimension writes, request
// stimulus with random gaps, response back-pressure and the verdict.
// Depends on sqmm_pkg, sqmm_req_if, sqmm_rsp_if, sqmm_checker and square_int_matrix_multiply.
module square_int_matrix_multiply_tb;
   import sqmm_pkg::*;

   localparam int MAX_DIM      = 8;
   // Covers the issue, cell-chain and result phases of one product row, with padding,
   // so nothing can still be in flight when the dimension register changes.
   localparam int DRAIN_CYCLES = 2*MAX_DIM + MAX_DIM + 5 + 16;
   localparam int ITEM_TARGET  = 210;
   localparam int MAX_GAP      = 17;
   localparam int LIMIT_NS     = 20_000_000;   // watchdog limit, in ns
   localparam logic [KIND_W-1:0] REQ_UNUSED = 2'd3;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [DIM_W-1:0] csr_wdata;
   int               fail_count;
   int               pending_count;

   sqmm_req_if req_bus();
   sqmm_rsp_if rsp_bus();

   // Which A/B slots hold a value since reset; a compute must never read an unwritten one.
   logic [MAX_DIM*MAX_DIM-1:0] a_written = '0;
   logic [MAX_DIM*MAX_DIM-1:0] b_written = '0;
   int active_dim    = MAX_DIM;
   int item_count    = 0;
   int req_gap_max   = 0;   // 0 gives back-to-back transfers
   int rsp_stall_max = 0;

   square_int_matrix_multiply #(.MAX_DIM(MAX_DIM)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   sqmm_checker #(.MAX_DIM(MAX_DIM)) u_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Element values lean on the corners of the signed range so wrap-around gets exercised.
   function automatic logic [DATA_W-1:0] element_value();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         4, 5: return $urandom_range(0, 15) - 8;
         default: return $urandom();
      endcase
   endfunction

   // One request transfer. valid stays high after the transfer so the next item can go
   // back-to-back; it drops when a gap is drawn and before a dimension change or the end.
   task automatic send_req(input logic [KIND_W-1:0] kind, input int row,
                           input int col, input logic [DATA_W-1:0] value);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.row      <= IDX_W'(row);
      req_bus.col      <= IDX_W'(col);
      req_bus.value    <= value;
      do @(posedge clock); while (!req_bus.ready);
      if (kind == REQ_WRITE_A)
         a_written[row*MAX_DIM + col] = 1'b1;
      if (kind == REQ_WRITE_B)
         b_written[row*MAX_DIM + col] = 1'b1;
      item_count++;
   endtask

   // Fill every slot the product will read that has not been written yet, then compute.
   // Row, col and value of the compute itself are don't-cares and get random bits.
   task automatic issue_compute();
      for (int i = 0; i < active_dim; i++) begin
         for (int j = 0; j < active_dim; j++) begin
            if (!a_written[i*MAX_DIM + j])
               send_req(REQ_WRITE_A, i, j, element_value());
            if (!b_written[i*MAX_DIM + j])
               send_req(REQ_WRITE_B, i, j, element_value());
         end
      end
      send_req(REQ_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom());
   endtask

   // Dimension changes only while the block is idle: every expected element has arrived
   // (pending_count is registered, hence a clock edge first) and the pipeline has drained.
   task automatic set_dimension(input logic [DIM_W-1:0] dim);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= dim;
      @(posedge clock);
      csr_we    <= 1'b0;
      // zero acts as 1, anything past the array size saturates
      active_dim = (dim == 0) ? 1 : (dim > MAX_DIM) ? MAX_DIM : int'(dim);
   endtask

   // Response side: a fresh stall per element, up to MAX_GAP, or none at all in some phases.
   initial begin : rsp_sink
      int stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   initial begin : stimulus
      int               phase;
      int               n_items;
      int               pick;
      logic [DIM_W-1:0] dim;
      logic [KIND_W-1:0] kind;

      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_wdata        <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.req_type <= REQ_WRITE_A;
      req_bus.row      <= '0;
      req_bus.col      <= '0;
      req_bus.value    <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // Dimension 0 behaves as 1x1: most negative times -1 wraps back to itself.
      set_dimension(4'd0);
      send_req(REQ_WRITE_A, 0, 0, 32'h8000_0000);
      send_req(REQ_WRITE_B, 0, 0, 32'hFFFF_FFFF);
      issue_compute();
      // largest positive squared wraps to 1
      send_req(REQ_WRITE_A, 0, 0, 32'h7FFF_FFFF);
      send_req(REQ_WRITE_B, 0, 0, 32'h7FFF_FFFF);
      issue_compute();
      // unused request code: must be dropped silently
      send_req(REQ_UNUSED, 7, 7, 32'hFFFF_FFFF);
      // top corner lies outside the 1x1 product: stored, must not leak into the result
      send_req(REQ_WRITE_A, 7, 7, 32'h1234_5678);
      send_req(REQ_WRITE_B, 7, 7, 32'h8765_4321);
      issue_compute();

      // 2x2 with extreme entries, both sides stalling hard
      req_gap_max   = MAX_GAP;
      rsp_stall_max = MAX_GAP;
      set_dimension(4'd2);
      send_req(REQ_WRITE_A, 0, 0, 32'h8000_0000);
      send_req(REQ_WRITE_A, 0, 1, 32'h7FFF_FFFF);
      send_req(REQ_WRITE_A, 1, 0, 32'hFFFF_FFFF);
      send_req(REQ_WRITE_A, 1, 1, 32'h0000_0000);
      send_req(REQ_WRITE_B, 0, 0, 32'h7FFF_FFFF);
      send_req(REQ_WRITE_B, 0, 1, 32'h8000_0000);
      send_req(REQ_WRITE_B, 1, 0, 32'h0000_0001);
      send_req(REQ_WRITE_B, 1, 1, 32'hFFFF_FFFF);
      issue_compute();

      // --- random part ---
      // Each phase picks a dimension and an idling style, then mixes writes inside the
      // active square, writes anywhere, computes and dropped codes. Settings 15, 8 and 9
      // are forced in early phases; later phases mostly stay at 4 or below.
      phase = 0;
      while (item_count < ITEM_TARGET) begin
         if (phase == 0)
            dim = 4'd15;
         else if (phase == 1)
            dim = 4'd1;
         else if (phase == 3)
            dim = 4'd8;
         else if (phase == 5)
            dim = 4'd9;
         else if ($urandom_range(0, 9) < 8)
            dim = DIM_W'($urandom_range(0, 4));
         else
            dim = DIM_W'($urandom_range(5, MAX_DIM));
         req_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
         rsp_stall_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
         set_dimension(dim);

         n_items = $urandom_range(6, 20);
         repeat (n_items) begin
            pick = $urandom_range(0, 99);
            kind = ($urandom_range(0, 1) == 0) ? REQ_WRITE_A : REQ_WRITE_B;
            if (pick < 55)
               send_req(kind, $urandom_range(0, active_dim - 1),
                        $urandom_range(0, active_dim - 1), element_value());
            else if (pick < 68)
               send_req(kind, $urandom_range(0, 7), $urandom_range(0, 7), element_value());
            else if (pick < 90)
               issue_compute();
            else
               send_req(REQ_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7), $urandom());
         end
         issue_compute();
         phase++;
      end

      // --- wind down ---
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Hard stop in case a handshake never completes.
   initial begin : watchdog
      #(LIMIT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: square_int_matrix_multiply.f
sv/sqmm_pkg.sv
sv/sqmm_req_if.sv
sv/sqmm_rsp_if.sv
sv/sqmm_cell.sv
sv/square_int_matrix_multiply.sv
verif/sqmm_checker.sv
verif/square_int_matrix_multiply_tb.sv
